// File: rtl/core/slc_pkg.sv
// shared types and constants of the set-associative lru cache model
`timescale 1ns / 1ps

package slc_pkg;

   localparam int SLC_SET_BITS_W    = 3;
   localparam int SLC_OFFSET_BITS_W = 4;
   localparam int SLC_WAYS_W        = 4;
   localparam int SLC_WAYS_CMP_W    = SLC_WAYS_W + 1;
   localparam int SLC_MAX_OFFSET    = 12;
   localparam int SLC_TALLY_W       = 32;
   localparam int SLC_STAMP_W       = 64;
   localparam int SLC_IN_ADDR_W     = 64;
   localparam int SLC_CSR_INDEX_W   = 2;
   localparam int SLC_CSR_DATA_W    = 4;

   localparam logic [SLC_TALLY_W-1:0] SLC_TALLY_MAX = '1;

   localparam logic [SLC_CSR_INDEX_W-1:0] SLC_CSR_SET_INDEX_BITS = 2'd0;
   localparam logic [SLC_CSR_INDEX_W-1:0] SLC_CSR_OFFSET_BITS    = 2'd1;
   localparam logic [SLC_CSR_INDEX_W-1:0] SLC_CSR_WAYS_IN_USE    = 2'd2;

   typedef struct packed {
      logic [SLC_SET_BITS_W-1:0]    set_index_bits;
      logic [SLC_OFFSET_BITS_W-1:0] offset_bits;
      logic [SLC_WAYS_W-1:0]        ways_in_use;
   } slc_cfg_type;

   typedef struct packed {
      logic                   was_hit;
      logic                   was_eviction;
      logic [SLC_TALLY_W-1:0] hits_total;
      logic [SLC_TALLY_W-1:0] misses_total;
      logic [SLC_TALLY_W-1:0] evictions_total;
   } slc_result_type;

endpackage

// File: rtl/core/slc_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module slc_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/slc_front.sv
// front end: configuration registers and address split into set and tag
`timescale 1ns / 1ps

module slc_front
   import slc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SLC_CSR_INDEX_W-1:0] csr_index,
   input  logic [SLC_CSR_DATA_W-1:0]  csr_data,
   output slc_cfg_type                cfg,
   input  logic [SLC_IN_ADDR_W-1:0]   req_address,
   output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] item_set,
   output logic [ADDR_WIDTH-1:0]      item_tag
);

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   slc_cfg_type     cfg_ff;
   logic [3:0]      sbits_eff;
   logic [3:0]      obits_eff;
   logic [ADDR_WIDTH-1:0] addr;
   logic [ADDR_WIDTH-1:0] above;
   logic [SET_W-1:0]      set_mask;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_index_bits <= '0;
         cfg_ff.offset_bits    <= '0;
         cfg_ff.ways_in_use    <= SLC_WAYS_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            SLC_CSR_SET_INDEX_BITS: cfg_ff.set_index_bits <= csr_data[SLC_SET_BITS_W-1:0];
            SLC_CSR_OFFSET_BITS:    cfg_ff.offset_bits    <= csr_data[SLC_OFFSET_BITS_W-1:0];
            SLC_CSR_WAYS_IN_USE:    cfg_ff.ways_in_use    <= csr_data[SLC_WAYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sbits_eff = ({1'b0, cfg_ff.set_index_bits} > 4'(MAX_SET_BITS))
                ? 4'(MAX_SET_BITS) : {1'b0, cfg_ff.set_index_bits};
      obits_eff = (cfg_ff.offset_bits > 4'(SLC_MAX_OFFSET))
                ? 4'(SLC_MAX_OFFSET) : cfg_ff.offset_bits;
      addr      = req_address[ADDR_WIDTH-1:0];
      above     = addr >> obits_eff;
      set_mask  = ~({SET_W{1'b1}} << sbits_eff);
      item_set  = above[SET_W-1:0] & set_mask;
      item_tag  = above >> sbits_eff;
   end

endmodule

// File: rtl/core/slc_back.sv
// back end: set row store, hit and lru selection, use clock and totals
`timescale 1ns / 1ps

module slc_back
   import slc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  slc_cfg_type           cfg,
   input  logic                  item_valid,
   input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] item_set,
   input  logic [ADDR_WIDTH-1:0] item_tag,
   output logic                  item_pop,
   output slc_result_type        res_data,
   output logic                  res_push,
   input  logic                  res_full
);

   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   typedef enum logic {
      S_LOOKUP,
      S_DECIDE
   } state_type;

   state_type state_ff;

   // one row per set: valid bits, tags and stamps of all ways
   logic [MAX_WAYS-1:0]                  valid_mem [NUM_SETS];
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_mem   [NUM_SETS];
   logic [MAX_WAYS-1:0][SLC_STAMP_W-1:0] stamp_mem [NUM_SETS];
   logic [NUM_SETS-1:0]                  row_ok_ff;

   logic [MAX_WAYS-1:0]                  rd_valid_ff;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tag_ff;
   logic [MAX_WAYS-1:0][SLC_STAMP_W-1:0] rd_stamp_ff;
   logic                                 row_ok_rd_ff;
   logic [SET_W-1:0]                     set_ff;
   logic [ADDR_WIDTH-1:0]                tag_ff;

   logic [SLC_STAMP_W-1:0] use_clock_ff, use_clock_in;
   logic [SLC_TALLY_W-1:0] hit_tally_ff, hit_tally_in;
   logic [SLC_TALLY_W-1:0] miss_tally_ff, miss_tally_in;
   logic [SLC_TALLY_W-1:0] evict_tally_ff, evict_tally_in;

   logic [SLC_WAYS_CMP_W-1:0]            ways_eff;
   logic [MAX_WAYS-1:0]                  in_use, eff_valid, match, empty_way, oldest;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  eff_tag;
   logic [MAX_WAYS-1:0][SLC_STAMP_W-1:0] eff_stamp;
   logic [WAY_W-1:0]                     hit_way, empty_idx, lru_way, pick;
   logic                                 hit, any_empty, evict;
   logic [MAX_WAYS-1:0]                  new_valid;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  new_tag;
   logic [MAX_WAYS-1:0][SLC_STAMP_W-1:0] new_stamp;

   assign item_pop = (state_ff == S_LOOKUP) && item_valid && !res_full;
   assign res_push = (state_ff == S_DECIDE);

   always_comb begin
      if (cfg.ways_in_use == '0) begin
         ways_eff = SLC_WAYS_CMP_W'(1);
      end else if ({1'b0, cfg.ways_in_use} > SLC_WAYS_CMP_W'(MAX_WAYS)) begin
         ways_eff = SLC_WAYS_CMP_W'(MAX_WAYS);
      end else begin
         ways_eff = {1'b0, cfg.ways_in_use};
      end
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]    = SLC_WAYS_CMP_W'(w) < ways_eff;
         eff_valid[w] = row_ok_rd_ff & rd_valid_ff[w];
         eff_tag[w]   = row_ok_rd_ff ? rd_tag_ff[w] : '0;
         eff_stamp[w] = row_ok_rd_ff ? rd_stamp_ff[w] : '0;
         match[w]     = in_use[w] & eff_valid[w] & (eff_tag[w] == tag_ff);
         empty_way[w] = in_use[w] & ~eff_valid[w];
      end
      // first way with the smallest stamp
      for (int w = 0; w < MAX_WAYS; w++) begin
         oldest[w] = in_use[w];
         for (int v = 0; v < MAX_WAYS; v++) begin
            if (in_use[v] && (v < w)) begin
               oldest[w] = oldest[w] & (eff_stamp[w] < eff_stamp[v]);
            end else if (in_use[v] && (v > w)) begin
               oldest[w] = oldest[w] & (eff_stamp[w] <= eff_stamp[v]);
            end
         end
      end
      hit       = |match;
      any_empty = |empty_way;
      hit_way   = '0;
      empty_idx = '0;
      lru_way   = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_way[w]) begin
            empty_idx = WAY_W'(w);
         end
         if (oldest[w]) begin
            lru_way = WAY_W'(w);
         end
      end
      evict = !hit && !any_empty;
      pick  = hit ? hit_way : (any_empty ? empty_idx : lru_way);

      use_clock_in   = use_clock_ff + 1'b1;
      hit_tally_in   = (hit && hit_tally_ff != SLC_TALLY_MAX)
                     ? hit_tally_ff + 1'b1 : hit_tally_ff;
      miss_tally_in  = (!hit && miss_tally_ff != SLC_TALLY_MAX)
                     ? miss_tally_ff + 1'b1 : miss_tally_ff;
      evict_tally_in = (evict && evict_tally_ff != SLC_TALLY_MAX)
                     ? evict_tally_ff + 1'b1 : evict_tally_ff;

      new_valid       = eff_valid;
      new_tag         = eff_tag;
      new_stamp       = eff_stamp;
      new_valid[pick] = 1'b1;
      new_tag[pick]   = tag_ff;
      new_stamp[pick] = use_clock_in;

      res_data.was_hit         = hit;
      res_data.was_eviction    = evict;
      res_data.hits_total      = hit_tally_in;
      res_data.misses_total    = miss_tally_in;
      res_data.evictions_total = evict_tally_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_LOOKUP;
         row_ok_ff      <= '0;
         use_clock_ff   <= '0;
         hit_tally_ff   <= '0;
         miss_tally_ff  <= '0;
         evict_tally_ff <= '0;
      end else begin
         unique case (state_ff)
            S_LOOKUP: begin
               if (item_pop) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               state_ff          <= S_LOOKUP;
               row_ok_ff[set_ff] <= 1'b1;
               use_clock_ff      <= use_clock_in;
               hit_tally_ff      <= hit_tally_in;
               miss_tally_ff     <= miss_tally_in;
               evict_tally_ff    <= evict_tally_in;
            end
            default: begin
               state_ff <= S_LOOKUP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rd_valid_ff  <= valid_mem[item_set];
         rd_tag_ff    <= tag_mem[item_set];
         rd_stamp_ff  <= stamp_mem[item_set];
         row_ok_rd_ff <= row_ok_ff[item_set];
         set_ff       <= item_set;
         tag_ff       <= item_tag;
      end
      if (state_ff == S_DECIDE) begin
         valid_mem[set_ff] <= new_valid;
         tag_mem[set_ff]   <= new_tag;
         stamp_mem[set_ff] <= new_stamp;
      end
   end

endmodule

// File: rtl/core/set_assoc_lru_cache_model.sv
// top level of the set-associative lru cache tag model
`timescale 1ns / 1ps

// Each address word pushed on req_ is split by the configured offset and set
// bit counts, queued, and looked up in a set-associative tag store with lru
// replacement; one result word per address appears on rsp_ in order. The back
// end first reads the set's row (tags, stamps, valid bits of every way) from
// the row store into registers, then compares all ways at once, picks the
// way and writes the row back, taking no new address until then. A pushed
// address passes through the request queue, the row read registers and the
// result queue before rsp_ shows its result. Reset clears per-set row valid
// flags at once, so there is no clearing pass. Write csr_ only while idle.

module set_assoc_lru_cache_model
   import slc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [SLC_IN_ADDR_W-1:0]   req_address,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_was_hit,
   output logic                       rsp_was_eviction,
   output logic [SLC_TALLY_W-1:0]     rsp_hits_total,
   output logic [SLC_TALLY_W-1:0]     rsp_misses_total,
   output logic [SLC_TALLY_W-1:0]     rsp_evictions_total,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SLC_CSR_INDEX_W-1:0] csr_index,
   input  logic [SLC_CSR_DATA_W-1:0]  csr_data
);

   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ITEM_W = SET_W + ADDR_WIDTH;
   localparam int RES_W  = $bits(slc_result_type);

   slc_cfg_type           cfg;
   logic [SET_W-1:0]      front_set, back_set;
   logic [ADDR_WIDTH-1:0] front_tag, back_tag;
   logic                  mid_empty, item_pop;
   slc_result_type        res_data, rsp_word;
   logic                  res_push, res_full;

   slc_front #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cfg         (cfg),
      .req_address (req_address),
      .item_set    (front_set),
      .item_tag    (front_tag)
   );

   slc_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({front_set, front_tag}),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  ({back_set, back_tag}),
      .empty     (mid_empty)
   );

   slc_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (!mid_empty),
      .item_set   (back_set),
      .item_tag   (back_tag),
      .item_pop   (item_pop),
      .res_data   (res_data),
      .res_push   (res_push),
      .res_full   (res_full)
   );

   slc_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_word),
      .empty     (rsp_empty)
   );

   assign rsp_was_hit         = rsp_word.was_hit;
   assign rsp_was_eviction    = rsp_word.was_eviction;
   assign rsp_hits_total      = rsp_word.hits_total;
   assign rsp_misses_total    = rsp_word.misses_total;
   assign rsp_evictions_total = rsp_word.evictions_total;

endmodule

// File: rtl/core/slc_checker.sv
// port checker for the cache model and its bind to the top level
`timescale 1ns / 1ps

module slc_checker
   import slc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic                       rsp_was_hit,
   input logic                       rsp_was_eviction,
   input logic [SLC_TALLY_W-1:0]     rsp_hits_total,
   input logic [SLC_TALLY_W-1:0]     rsp_misses_total,
   input logic [SLC_TALLY_W-1:0]     rsp_evictions_total
);

   // no result word right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // an eviction only comes with a miss
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_was_eviction) |-> (!rsp_was_hit && rsp_evictions_total != '0))
      else $error("eviction flagged on a hit or with zero eviction total");

   // the total for the kind of access shown has counted it
   a_totals_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_was_hit ? (rsp_hits_total != '0) : (rsp_misses_total != '0)))
      else $error("running total does not include the shown access");

   // a word not taken stays on the ports
   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hits_total)
         && $stable(rsp_misses_total) && $stable(rsp_was_hit)))
      else $error("result word changed before it was taken");

endmodule

bind set_assoc_lru_cache_model slc_checker u_slc_checker (.*);
